// ----- src/vstg_pkg.sv -----
// Package for the vector stroke text generator: constants, types and the glyph stroke ROM.
`default_nettype none
package vstg_pkg;

  localparam int VSTG_COORD_BITS = 16;
  localparam int GU_W            = 10;
  localparam int MUL_W           = 4;
  localparam int PROD_W          = MUL_W + GU_W;
  localparam int ORG_W           = 16;
  localparam int NGLYPH          = 37;
  localparam int MAXPTS          = 9;
  localparam int GIDX_W          = $clog2(NGLYPH);
  localparam int PIDX_W          = $clog2(MAXPTS);

  // Character codes.
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [GIDX_W-1:0] GIDX_DIGIT0 = GIDX_W'(26);
  localparam logic [GIDX_W-1:0] GIDX_DOT    = GIDX_W'(36);

  // Multipliers of the glyph unit for the cursor moves.
  localparam logic [MUL_W-1:0] ADV_X_MUL = MUL_W'(10);
  localparam logic [MUL_W-1:0] NL_Y_MUL  = MUL_W'(15);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_GLYPH_UNIT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ADV
  } vstg_state_e;

  // Operation for the shared step unit: x = bx + mul_x*gu, y = by +/- mul_y*gu.
  typedef struct packed {
    logic [MUL_W-1:0] mul_x;
    logic [MUL_W-1:0] mul_y;
    logic             sub_y;
  } step_op_t;

  // One stored point: stroke start flag, x and y in quarter units.
  typedef logic [2*MUL_W:0] pt_t;
  typedef pt_t [0:MAXPTS-1] pts_t;

  typedef struct packed {
    logic [PIDX_W-1:0] len;
    pts_t              pts;
  } glyph_t;

  localparam pt_t NO_PT = '0;

  function automatic pt_t pt(input int x, input int y);
    logic [MUL_W-1:0] xb;
    logic [MUL_W-1:0] yb;
    xb = MUL_W'(x);
    yb = MUL_W'(y);
    return {1'b0, xb, yb};
  endfunction

  function automatic pt_t st(input int x, input int y);
    logic [MUL_W-1:0] xb;
    logic [MUL_W-1:0] yb;
    xb = MUL_W'(x);
    yb = MUL_W'(y);
    return {1'b1, xb, yb};
  endfunction

  function automatic glyph_t glyph_rom(input logic [GIDX_W-1:0] g);
    glyph_t r;
    r.len = '0;
    r.pts = '{default: NO_PT};
    case (g)
      6'd0: begin
        r.len = 4'd7;
        r.pts = '{st(0,0), pt(0,8), pt(4,12), pt(8,8), pt(8,0), st(0,4), pt(8,4),
                  NO_PT, NO_PT};
      end
      6'd1: begin
        r.len = 4'd9;
        r.pts = '{st(4,6), pt(8,3), pt(4,0), pt(0,0), pt(0,12), pt(4,12), pt(8,9),
                  pt(4,6), pt(0,6)};
      end
      6'd2: begin
        r.len = 4'd6;
        r.pts = '{st(8,11), pt(4,12), pt(0,8), pt(0,4), pt(4,0), pt(8,1),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd3: begin
        r.len = 4'd7;
        r.pts = '{st(0,0), pt(0,12), pt(4,12), pt(8,8), pt(8,4), pt(4,0), pt(0,0),
                  NO_PT, NO_PT};
      end
      6'd4: begin
        r.len = 4'd6;
        r.pts = '{st(8,12), pt(0,12), pt(0,0), pt(8,0), st(0,6), pt(4,6),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd5: begin
        r.len = 4'd5;
        r.pts = '{st(8,12), pt(0,12), pt(0,0), st(0,6), pt(4,6),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd6: begin
        r.len = 4'd7;
        r.pts = '{st(8,11), pt(4,12), pt(0,8), pt(0,4), pt(4,0), pt(8,4), pt(4,4),
                  NO_PT, NO_PT};
      end
      6'd7: begin
        r.len = 4'd6;
        r.pts = '{st(0,0), pt(0,12), st(0,6), pt(8,6), st(8,12), pt(8,0),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd8: begin
        r.len = 4'd6;
        r.pts = '{st(0,0), pt(8,0), st(0,12), pt(8,12), st(4,0), pt(4,12),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd9: begin
        r.len = 4'd5;
        r.pts = '{st(4,12), pt(8,12), pt(8,4), pt(4,0), pt(0,4),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd10: begin
        r.len = 4'd5;
        r.pts = '{st(0,0), pt(0,12), st(8,12), pt(0,6), pt(8,0),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd11: begin
        r.len = 4'd3;
        r.pts = '{st(0,12), pt(0,0), pt(8,0),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd12: begin
        r.len = 4'd7;
        r.pts = '{st(0,0), pt(0,8), pt(2,12), pt(4,4), pt(6,12), pt(8,8), pt(8,0),
                  NO_PT, NO_PT};
      end
      6'd13: begin
        r.len = 4'd4;
        r.pts = '{st(0,0), pt(0,12), pt(8,0), pt(8,12),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd14: begin
        r.len = 4'd7;
        r.pts = '{st(0,4), pt(0,8), pt(4,12), pt(8,8), pt(8,4), pt(4,0), pt(0,4),
                  NO_PT, NO_PT};
      end
      6'd15: begin
        r.len = 4'd6;
        r.pts = '{st(0,0), pt(0,12), pt(4,12), pt(8,8), pt(4,4), pt(0,4),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd16: begin
        r.len = 4'd9;
        r.pts = '{st(0,4), pt(0,8), pt(4,12), pt(8,8), pt(8,4), pt(4,0), pt(0,4),
                  st(4,4), pt(8,0)};
      end
      6'd17: begin
        r.len = 4'd8;
        r.pts = '{st(0,0), pt(0,12), pt(4,12), pt(8,8), pt(4,4), pt(0,4), st(4,4),
                  pt(8,0), NO_PT};
      end
      6'd18: begin
        r.len = 4'd6;
        r.pts = '{st(8,12), pt(4,12), pt(0,8), pt(8,4), pt(4,0), pt(0,0),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd19: begin
        r.len = 4'd4;
        r.pts = '{st(0,12), pt(8,12), st(4,12), pt(4,0),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd20: begin
        r.len = 4'd5;
        r.pts = '{st(0,12), pt(0,2), pt(4,0), pt(8,2), pt(8,12),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd21: begin
        r.len = 4'd5;
        r.pts = '{st(0,12), pt(0,8), pt(4,0), pt(8,8), pt(8,12),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd22: begin
        r.len = 4'd7;
        r.pts = '{st(0,12), pt(0,4), pt(2,0), pt(4,8), pt(6,0), pt(8,4), pt(8,12),
                  NO_PT, NO_PT};
      end
      6'd23: begin
        r.len = 4'd4;
        r.pts = '{st(0,12), pt(8,0), st(0,0), pt(8,12),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd24: begin
        r.len = 4'd5;
        r.pts = '{st(0,12), pt(4,4), pt(4,0), st(4,4), pt(8,12),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd25: begin
        r.len = 4'd4;
        r.pts = '{st(0,12), pt(8,12), pt(0,0), pt(8,0),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd26: begin
        r.len = 4'd9;
        r.pts = '{st(0,4), pt(0,8), pt(4,12), pt(8,8), pt(8,4), pt(4,0), pt(0,4),
                  st(0,4), pt(8,8)};
      end
      6'd27: begin
        r.len = 4'd2;
        r.pts = '{st(4,12), pt(4,0),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd28: begin
        r.len = 4'd5;
        r.pts = '{st(0,8), pt(4,12), pt(8,8), pt(0,0), pt(8,0),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd29: begin
        r.len = 4'd6;
        r.pts = '{st(0,12), pt(8,12), pt(8,0), pt(0,0), st(0,6), pt(8,6),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd30: begin
        r.len = 4'd5;
        r.pts = '{st(0,12), pt(0,4), pt(8,4), pt(8,12), pt(8,0),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd31: begin
        r.len = 4'd6;
        r.pts = '{st(8,12), pt(0,12), pt(0,6), pt(8,6), pt(8,0), pt(0,0),
                  NO_PT, NO_PT, NO_PT};
      end
      6'd32: begin
        r.len = 4'd5;
        r.pts = '{st(0,12), pt(0,0), pt(8,0), pt(8,6), pt(0,6),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd33: begin
        r.len = 4'd3;
        r.pts = '{st(0,12), pt(8,12), pt(8,0),
                  NO_PT, NO_PT, NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd34: begin
        r.len = 4'd7;
        r.pts = '{st(0,0), pt(0,12), pt(8,12), pt(8,0), pt(0,0), st(0,6), pt(8,6),
                  NO_PT, NO_PT};
      end
      6'd35: begin
        r.len = 4'd5;
        r.pts = '{st(8,0), pt(8,12), pt(0,12), pt(0,6), pt(8,6),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      6'd36: begin
        r.len = 4'd5;
        r.pts = '{st(3,0), pt(3,2), pt(5,2), pt(5,0), pt(3,0),
                  NO_PT, NO_PT, NO_PT, NO_PT};
      end
      default: begin
        r.len = '0;
        r.pts = '{default: NO_PT};
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/vstg_step_unit.sv -----
// Shared step unit: scales glyph-unit multiples and adds them to a coordinate pair.
`default_nettype none
module vstg_step_unit #(
  parameter int COORD_BITS = vstg_pkg::VSTG_COORD_BITS
) (
  input  wire logic [COORD_BITS-1:0]     base_x_i,
  input  wire logic [COORD_BITS-1:0]     base_y_i,
  input  wire logic [vstg_pkg::GU_W-1:0] gu_i,
  input  wire vstg_pkg::step_op_t        op_i,
  output logic      [COORD_BITS-1:0]     res_x_o,
  output logic      [COORD_BITS-1:0]     res_y_o
);
  import vstg_pkg::*;

  localparam int SUM_W = COORD_BITS + PROD_W;

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [SUM_W-1:0]  add_y;
  logic [SUM_W-1:0]  sum_x;
  logic [SUM_W-1:0]  sum_y;

  // Narrow products: a 4-bit multiple times the 10-bit glyph unit.
  assign prod_x = PROD_W'(op_i.mul_x) * PROD_W'(gu_i);
  assign prod_y = PROD_W'(op_i.mul_y) * PROD_W'(gu_i);

  // Subtraction is an add of the two's complement; everything wraps.
  assign add_y = op_i.sub_y ? (~SUM_W'(prod_y) + SUM_W'(1)) : SUM_W'(prod_y);
  assign sum_x = SUM_W'(base_x_i) + SUM_W'(prod_x);
  assign sum_y = SUM_W'(base_y_i) + add_y;

  assign res_x_o = sum_x[COORD_BITS-1:0];
  assign res_y_o = sum_y[COORD_BITS-1:0];

endmodule
`default_nettype wire

// ----- src/vector_stroke_text_generator.sv -----
// Vector stroke text generator top level: sequencer, cursor, configuration and stream ports.
// A glyph of n points (2..9) is walked in order: the code is accepted, each vertex
// passes through the shared step unit in turn, then the cursor advances. Space and
// newline are accepted and then move the cursor; other codes are only accepted.
// Throughput: at most one vertex per cycle (single shared step unit) unless the output stalls.
// Reset (rst_ni, asynchronous, active low): sequencer idle, no result pending,
// cursor at (0,0), origin at (0,0) and glyph unit 3.
`default_nettype none
module vector_stroke_text_generator #(
  parameter int COORD_BITS = vstg_pkg::VSTG_COORD_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tuser,   // [0] first_of_string
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata, // vertex_x, then vertex_y
  output logic             m_axis_tuser,   // [0] new_strip
  output logic             m_axis_tlast,   // last vertex of the glyph
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import vstg_pkg::*;

  localparam int OUT_TDATA_W = ((2*COORD_BITS+7)/8)*8;

  // Configuration registers.
  logic signed [ORG_W-1:0] origin_x_q;
  logic signed [ORG_W-1:0] origin_y_q;
  logic [GU_W-1:0]         glyph_unit_q;
  reg_idx_e                reg_idx;
  logic                    cfg_wr;

  // Sequencer and cursor.
  vstg_state_e             state_q, state_d;
  logic [PIDX_W-1:0]       k_q, k_d;
  logic [PIDX_W-1:0]       len_q;
  pts_t                    pts_q;
  logic                    nl_q;
  logic [COORD_BITS-1:0]   cursor_x_q, cursor_y_q;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]   out_x_q, out_y_q;
  logic                    out_strip_q, out_last_q;

  // Decode of the incoming code.
  logic                    in_accept;
  logic                    is_glyph, is_space, is_nl;
  logic [GIDX_W-1:0]       gidx;
  glyph_t                  glyph;

  // Shared unit.
  step_op_t                op;
  logic [COORD_BITS-1:0]   res_x, res_y;
  pt_t                     cur_pt;
  logic                    out_free;
  logic                    emit_fire, adv_fire, last_pt;

  // ---------------------------------------------------------------------
  // Configuration port: writes complete in the access phase, reads are
  // combinational. Addresses past the register list are ignored.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      glyph_unit_q <= GU_W'(3);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X:   origin_x_q   <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:   origin_y_q   <= pwdata[ORG_W-1:0];
        REG_GLYPH_UNIT: glyph_unit_q <= pwdata[GU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:   prdata = 32'(unsigned'(origin_x_q));
      REG_ORIGIN_Y:   prdata = 32'(unsigned'(origin_y_q));
      REG_GLYPH_UNIT: prdata = 32'(glyph_unit_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Code decode. Uppercase letters map to glyphs 0..25, digits follow, the period is
  // the last glyph. Space and newline only move the cursor; every other
  // code yields nothing.
  // ---------------------------------------------------------------------
  always_comb begin
    is_glyph = 1'b0;
    is_space = 1'b0;
    is_nl    = 1'b0;
    gidx     = '0;
    if (s_axis_tdata inside {[CHAR_A:CHAR_Z]}) begin
      is_glyph = 1'b1;
      gidx     = GIDX_W'(s_axis_tdata - CHAR_A);
    end else if (s_axis_tdata inside {[CHAR_0:CHAR_9]}) begin
      is_glyph = 1'b1;
      gidx     = GIDX_DIGIT0 + GIDX_W'(s_axis_tdata - CHAR_0);
    end else if (s_axis_tdata == CHAR_DOT) begin
      is_glyph = 1'b1;
      gidx     = GIDX_DOT;
    end else if (s_axis_tdata == CHAR_NL) begin
      is_nl    = 1'b1;
    end else if (s_axis_tdata == CHAR_SPACE) begin
      is_space = 1'b1;
    end
  end

  assign glyph     = glyph_rom(gidx);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Shared step unit. While walking a glyph it places the current point
  // relative to the cursor; in the advance cycle it moves the cursor right
  // by ten units and, for a newline, down by fifteen.
  // ---------------------------------------------------------------------
  assign cur_pt = pts_q[k_q];

  always_comb begin
    if (state_q == ST_ADV) begin
      op.mul_x = ADV_X_MUL;
      op.mul_y = nl_q ? NL_Y_MUL : '0;
      op.sub_y = nl_q;
    end else begin
      op.mul_x = cur_pt[2*MUL_W-1:MUL_W];
      op.mul_y = cur_pt[MUL_W-1:0];
      op.sub_y = 1'b0;
    end
  end

  vstg_step_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .base_x_i (cursor_x_q),
    .base_y_i (cursor_y_q),
    .gu_i     (glyph_unit_q),
    .op_i     (op),
    .res_x_o  (res_x),
    .res_y_o  (res_y)
  );

  // ---------------------------------------------------------------------
  // Sequencer. A vertex leaves for the output register whenever that
  // register is empty or being drained this cycle.
  // ---------------------------------------------------------------------
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_pt   = (k_q == len_q - PIDX_W'(1));
  assign emit_fire = (state_q == ST_EMIT) && out_free;
  assign adv_fire  = (state_q == ST_ADV);

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    s_axis_tready = 1'b0;
    out_valid_d   = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          k_d = '0;
          if (is_glyph) begin
            state_d = ST_EMIT;
          end else if (is_space || is_nl) begin
            state_d = ST_ADV;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (last_pt) begin
            state_d = ST_ADV;
          end else begin
            k_d = k_q + PIDX_W'(1);
          end
        end
      end
      ST_ADV: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload held for the walk.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      len_q <= glyph.len;
      pts_q <= glyph.pts;
      nl_q  <= is_nl;
    end
  end

  // Cursor: loaded from the origin by a string's first code, moved in the
  // advance cycle. The origin is sign-extended or cut to the coordinate width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else if (in_accept && s_axis_tuser) begin
      cursor_x_q <= COORD_BITS'(origin_x_q);
      cursor_y_q <= COORD_BITS'(origin_y_q);
    end else if (adv_fire) begin
      cursor_x_q <= res_x;
      cursor_y_q <= res_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_x_q     <= res_x;
      out_y_q     <= res_y;
      out_strip_q <= cur_pt[2*MUL_W];
      out_last_q  <= last_pt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_y_q, out_x_q});
  assign m_axis_tuser  = out_strip_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- tb/tb_vector_stroke_text_generator.sv -----
// Self-checking testbench for the vector stroke text generator: streams, registers, prediction.
`timescale 1ns / 100ps

module tb_vector_stroke_text_generator;
  import vstg_pkg::*;

  // Timing of the run. The settle time after the last vertex is generous, and the
  // watchdog limit must stay well above the long receiver hold-off.
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Cursor moves, in glyph units.
  localparam int ADVANCE_UNITS = 10;
  localparam int NEWLINE_UNITS = 15;

  typedef struct packed {
    logic [7:0] code;
    logic       first;
  } char_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        strip;
    logic        last;
  } vertex_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] char_code
  logic        s_axis_tuser = 1'b0; // [0] first_of_string

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] vertex_x, [31:16] vertex_y
  logic        m_axis_tuser;        // [0] new_strip
  logic        m_axis_tlast;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vector_stroke_text_generator i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Glyph predictor.
  // Each glyph is written as a list of three-digit hex points separated by a
  // space: stroke-start flag, x and y in quarter units. Codes without a glyph
  // return an empty string.
  // ---------------------------------------------------------------------------
  function automatic string glyph_strokes(input logic [7:0] code);
    case (code)
      "A": return "100 008 04C 088 080 104 084";
      "B": return "146 083 040 000 00C 04C 089 046 006";
      "C": return "18B 04C 008 004 040 081";
      "D": return "100 00C 04C 088 084 040 000";
      "E": return "18C 00C 000 080 106 046";
      "F": return "18C 00C 000 106 046";
      "G": return "18B 04C 008 004 040 084 044";
      "H": return "100 00C 106 086 18C 080";
      "I": return "100 080 10C 08C 140 04C";
      "J": return "14C 08C 084 040 004";
      "K": return "100 00C 18C 006 080";
      "L": return "10C 000 080";
      "M": return "100 008 02C 044 06C 088 080";
      "N": return "100 00C 080 08C";
      "O": return "104 008 04C 088 084 040 004";
      "P": return "100 00C 04C 088 044 004";
      "Q": return "104 008 04C 088 084 040 004 144 080";
      "R": return "100 00C 04C 088 044 004 144 080";
      "S": return "18C 04C 008 084 040 000";
      "T": return "10C 08C 14C 040";
      "U": return "10C 002 040 082 08C";
      "V": return "10C 008 040 088 08C";
      "W": return "10C 004 020 048 060 084 08C";
      "X": return "10C 080 100 08C";
      "Y": return "10C 044 040 144 08C";
      "Z": return "10C 08C 000 080";
      "0": return "104 008 04C 088 084 040 004 104 088";
      "1": return "14C 040";
      "2": return "108 04C 088 000 080";
      "3": return "10C 08C 080 000 106 086";
      "4": return "10C 004 084 08C 080";
      "5": return "18C 00C 006 086 080 000";
      "6": return "10C 000 080 086 006";
      "7": return "10C 08C 080";
      "8": return "100 00C 08C 080 000 106 086";
      "9": return "180 08C 00C 006 086";
      ".": return "130 032 052 050 030";
      default: return "";
    endcase
  endfunction

  function automatic int hex_value(input byte digit);
    return (digit >= "A") ? int'(digit - "A") + 10 : int'(digit - "0");
  endfunction

  // Register copies and the text cursor, as the block should hold them.
  logic [15:0] start_x = '0;
  logic [15:0] start_y = '0;
  logic [9:0]  quarter_size = 10'd3;
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;

  vertex_t expected_vertices[$];

  // Works out the vertices of one accepted character and moves the cursor.
  // All sums wrap at 16 bits, just as the block's coordinates do.
  function automatic void draw_char(input logic [7:0] code, input logic first);
    string   strokes;
    int      npts;
    vertex_t v;
    strokes = glyph_strokes(code);
    if (first) begin
      pen_x = start_x;
      pen_y = start_y;
    end
    // Codes without a glyph, other than space and newline, leave the cursor alone.
    if (strokes.len() == 0 && code != CHAR_SPACE && code != CHAR_NL) return;
    if (code == CHAR_NL) begin
      pen_y = pen_y - 16'(NEWLINE_UNITS * int'(quarter_size));
    end
    npts = (strokes.len() + 1) / 4;
    for (int k = 0; k < npts; k++) begin
      v.x     = pen_x + 16'(hex_value(strokes[4*k+1]) * int'(quarter_size));
      v.y     = pen_y + 16'(hex_value(strokes[4*k+2]) * int'(quarter_size));
      v.strip = (strokes[4*k] == "1");
      v.last  = (k == npts - 1);
      expected_vertices.push_back(v);
    end
    pen_x = pen_x + 16'(ADVANCE_UNITS * int'(quarter_size));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. It works in bursts of random length; between bursts it leaves gaps
  // of random length, and sometimes none, so that long back-to-back runs occur.
  // An offered item is held until the rising edge at which it is taken.
  // ---------------------------------------------------------------------------
  char_item_t char_queue[$];
  char_item_t next_char;
  logic       char_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(negedge clk) begin
    if (rst_ni && !(s_axis_tvalid && !char_taken)) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (char_queue.size() != 0) begin
        next_char      = char_queue.pop_front();
        s_axis_tdata  <= next_char.code;
        s_axis_tuser  <= next_char.first;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It follows a 16-bit stall pattern that is rotated while a countdown
  // runs and reloaded with a new density when it ends, from always ready to mostly
  // stalled. On request it holds off for a long stretch so that the block backs
  // up and stops taking characters.
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pattern = '1;
  int          pattern_left = 0;
  int          hold_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      m_axis_tready <= 1'b0;
      holds_served  <= holds_served + 1;
      hold_left     <= LONG_HOLD;
    end else begin
      m_axis_tready <= ready_pattern[0];
      if (pattern_left == 0) begin
        pattern_left <= 64;
        case ($urandom_range(0, 3))
          0:       ready_pattern <= '1;
          1:       ready_pattern <= 16'($urandom());
          2:       ready_pattern <= 16'($urandom() & $urandom());
          default: ready_pattern <= 16'($urandom() | $urandom());
        endcase
      end else begin
        pattern_left  <= pattern_left - 1;
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Characters are predicted when taken, vertices are compared with
  // the oldest expectation. Any handshake on any port resets the idle count
  // that the watchdog looks at.
  // ---------------------------------------------------------------------------
  int      errors = 0;
  int      quiet_cycles = 0;
  vertex_t got_vertex;
  vertex_t want_vertex;

  always @(posedge clk) begin
    char_taken <= s_axis_tvalid && s_axis_tready;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        draw_char(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_vertex.x     = m_axis_tdata[15:0];
        got_vertex.y     = m_axis_tdata[31:16];
        got_vertex.strip = m_axis_tuser;
        got_vertex.last  = m_axis_tlast;
        if (expected_vertices.size() == 0) begin
          errors++;
          $display("%0t: vertex with nothing expected: x=%0d y=%0d strip=%0b last=%0b",
                   $time, $signed(got_vertex.x), $signed(got_vertex.y),
                   got_vertex.strip, got_vertex.last);
        end else begin
          want_vertex = expected_vertices.pop_front();
          if (got_vertex !== want_vertex) begin
            errors++;
            $display("%0t: vertex mismatch: expected x=%0d y=%0d strip=%0b last=%0b",
                     $time, $signed(want_vertex.x), $signed(want_vertex.y),
                     want_vertex.strip, want_vertex.last);
            $display("%0t:                    actual x=%0d y=%0d strip=%0b last=%0b",
                     $time, $signed(got_vertex.x), $signed(got_vertex.y),
                     got_vertex.strip, got_vertex.last);
          end
        end
      end
    end
  end

  // The watchdog ends a run that has stopped moving.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("vector_stroke_text_generator regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register write: setup cycle, then access cycle until pready. The predictor's
  // copy is updated at the same edge as the block's register.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'h0000, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ORIGIN_X: start_x = value;
      REG_ORIGIN_Y: start_y = value;
      default:      quarter_size = value[9:0];
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic setup_text(input logic [15:0] x0, input logic [15:0] y0,
                            input logic [9:0] unit);
    write_reg(REG_ORIGIN_X, x0);
    write_reg(REG_ORIGIN_Y, y0);
    write_reg(REG_GLYPH_UNIT, {6'b0, unit});
  endtask

  function automatic void queue_char(input logic [7:0] code, input logic first);
    char_item_t item;
    item.code  = code;
    item.first = first;
    char_queue.push_back(item);
  endfunction

  // Mostly words of printable characters that start a new string, with a few
  // stray string starts and some fully random codes as noise.
  function automatic void queue_text(input int count);
    int         word_left;
    int         pick;
    logic [7:0] code;
    word_left = 0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      code = 8'("A" + $urandom_range(0, 25));
      else if (pick < 70) code = 8'("0" + $urandom_range(0, 9));
      else if (pick < 78) code = CHAR_SPACE;
      else if (pick < 83) code = CHAR_DOT;
      else if (pick < 88) code = CHAR_NL;
      else                code = 8'($urandom_range(0, 255));
      if (word_left == 0) begin
        word_left = $urandom_range(1, 12);
        queue_char(code, 1'b1);
      end else begin
        word_left--;
        queue_char(code, $urandom_range(0, 19) == 0);
      end
    end
  endfunction

  // Waits until every character went in and every vertex came out, then lets
  // the block finish any trailing cursor move before registers are touched.
  // The check runs at the rising edge, where the sender's outputs are settled.
  task automatic wait_idle();
    while (char_queue.size() != 0 || s_axis_tvalid || expected_vertices.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni = 1'b1;

    // Directed part, with the reset settings: the longest and shortest glyphs,
    // the ends of the letter and digit ranges and their neighbors, space,
    // newline, lowercase, zero and all-ones codes, and a string start on a code
    // that draws nothing but still reloads the cursor.
    queue_char("A", 1'b1);
    queue_char("B", 1'b0);
    queue_char("Q", 1'b0);
    queue_char("Z", 1'b0);
    queue_char("0", 1'b0);
    queue_char("1", 1'b0);
    queue_char("9", 1'b0);
    queue_char(CHAR_DOT, 1'b0);
    queue_char(CHAR_SPACE, 1'b0);
    queue_char(CHAR_NL, 1'b0);
    queue_char("M", 1'b0);
    queue_char("a", 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char("L", 1'b0);
    queue_char(8'h80, 1'b1);
    queue_char("W", 1'b0);
    queue_char("@", 1'b0);
    queue_char("[", 1'b0);
    queue_char("/", 1'b0);
    queue_char(":", 1'b0);
    queue_char("-", 1'b0);
    queue_char(CHAR_NL, 1'b1);
    queue_char("R", 1'b0);
    wait_idle();

    // Largest origin and unit: the strings run off the positive edge and wrap.
    setup_text(16'h7FFF, 16'h7FFF, 10'd1023);
    queue_text(30);
    wait_idle();

    // Most negative origin and the smallest legal unit.
    setup_text(16'h8000, 16'h8000, 10'd1);
    queue_text(30);
    wait_idle();

    // A zero unit puts every vertex on the cursor and the cursor never moves.
    setup_text(16'h1234, 16'hFF9C, 10'd0);
    queue_text(20);
    wait_idle();

    // Random settings. In the second phase the receiver holds off for a long
    // stretch while characters keep coming, so the block backs up.
    for (int phase = 0; phase < 6; phase++) begin
      setup_text(16'($urandom()), 16'($urandom()),
                 ($urandom_range(0, 4) == 0) ? 10'($urandom_range(1, 1023))
                                             : 10'($urandom_range(1, 40)));
      queue_text(phase == 1 ? 70 : 50);
      if (phase == 1) hold_requests++;
      wait_idle();
    end

    if (errors == 0) begin
      $display("vector_stroke_text_generator regression: pass");
    end else begin
      $display("vector_stroke_text_generator regression: fail");
    end
    $finish;
  end

endmodule
